// File: rtl/spe_pkg.sv
// Shared types, constants and codes of the starfield projection engine.
package spe_pkg;

	localparam int COORD_IN_W = 11;
	localparam int DEPTH_W = 11;
	localparam int CFG_W = 11;
	localparam int COORD_W = 20;
	localparam int DOT_W = 2;
	localparam int SHADE_W = 5;
	localparam int OP_W = 2;
	localparam int INDEX_W = 8;
	localparam int STAR_W = 2 * COORD_IN_W + DEPTH_W;
	localparam int SHADE_TOP = 16;
	localparam int SHADE_STEPS = 16;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam int STAR_SLOTS_DEF = 256;
	localparam int PROJECTION_SHIFT_DEF = 8;
	localparam int DEPTH_MAX_DEF = 1024;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST = 11'd320;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 11'd200;
	localparam logic [CFG_W-1:0] FLY_SPEED_RST = 11'd4;

	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FLY_SPEED = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_DRAW = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_SETUP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] screen_width;
		logic [CFG_W-1:0] screen_height;
		logic [CFG_W-1:0] fly_speed;
	} cfg_t;

endpackage

// File: rtl/starfield_projection_engine_unit.sv
// Top level of the starfield projection engine: star table, sequencer and projection.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+----------------------------------------
//  item      | item_valid / item_stall      | op, star_index, new_x, new_y, new_depth
//  result    | result_valid / result_stall  | screen_x, screen_y, dot_size, shade
//  config    | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
// Load writes the table directly, advance reads it and then writes back. Draw reads the
// table, sets up, then computes one quotient bit per cycle through the two-lane serial
// divider, both coordinates at once, before loading the output register.
// One item at a time; the next beat is taken while a result still waits in the output register.
// Reset clears the sequencer, the output valid flag and the configuration; the star table
// holds garbage until written.
module starfield_projection_engine_unit #(
	parameter int STAR_SLOTS = spe_pkg::STAR_SLOTS_DEF,
	parameter int PROJECTION_SHIFT = spe_pkg::PROJECTION_SHIFT_DEF,
	parameter int DEPTH_MAX = spe_pkg::DEPTH_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [spe_pkg::OP_W-1:0]            op,
	input  logic [spe_pkg::INDEX_W-1:0]         star_index,
	input  logic signed [spe_pkg::COORD_IN_W-1:0] new_x,
	input  logic signed [spe_pkg::COORD_IN_W-1:0] new_y,
	input  logic [spe_pkg::DEPTH_W-1:0]         new_depth,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [spe_pkg::COORD_W-1:0]  screen_x,
	output logic signed [spe_pkg::COORD_W-1:0]  screen_y,
	output logic [spe_pkg::DOT_W-1:0]           dot_size,
	output logic [spe_pkg::SHADE_W-1:0]         shade,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spe_pkg::PADDR_W-1:0]         paddr,
	input  logic [spe_pkg::PDATA_W-1:0]         pwdata,
	output logic [spe_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	import spe_pkg::*;

	localparam int ADDR_W = STAR_SLOTS > 1 ? $clog2(STAR_SLOTS) : 1;
	localparam int IDX_CMP_W = $clog2(STAR_SLOTS + 1) > INDEX_W ?
		$clog2(STAR_SLOTS + 1) : INDEX_W;
	localparam int MAG_W = COORD_IN_W + PROJECTION_SHIFT;
	localparam int SUM_W = MAG_W > COORD_W ? MAG_W : COORD_W;
	localparam int DCMP_W = $clog2(DEPTH_MAX + 1) > DEPTH_W ?
		$clog2(DEPTH_MAX + 1) : DEPTH_W;
	localparam int SHADE_SH = $clog2(SHADE_STEPS);
	localparam int SHC_W = $clog2(SHADE_STEPS * DEPTH_MAX + 1) > DEPTH_W + SHADE_SH ?
		$clog2(SHADE_STEPS * DEPTH_MAX + 1) : DEPTH_W + SHADE_SH;
	localparam int DOT_NEAR = DEPTH_MAX / 3;
	localparam int DOT_MID = (2 * DEPTH_MAX) / 3;

	cfg_t cfg;
	state_t state_q, state_d;

	logic accept;
	logic [IDX_CMP_W-1:0] idx_ext;
	logic idx_ok;
	logic [DEPTH_W-1:0] depth_clamped;

	logic [OP_W-1:0] op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [COORD_IN_W-1:0] nx_q, ny_q;
	logic [DEPTH_W-1:0] nd_q;

	logic ram_we;
	logic [STAR_W-1:0] ram_wdata;
	logic [STAR_W-1:0] rd_data;
	logic [COORD_IN_W-1:0] rd_x, rd_y;
	logic [DEPTH_W-1:0] rd_d;
	logic [COORD_IN_W-1:0] abs_x, abs_y;

	logic div_start, div_done;
	logic [1:0][MAG_W-1:0] dividend, quotient;

	logic negx_q, negy_q, dz_q;
	logic [DOT_W-1:0] dot_q;
	logic [SHADE_W-1:0] shade_q;
	logic [SHADE_STEPS-1:0] shade_hit;
	logic [DOT_W-1:0] dot_d;

	logic load_out;
	logic out_full_q;
	logic [COORD_W-1:0] sx_q, sy_q;
	logic [DOT_W-1:0] dot_out_q;
	logic [SHADE_W-1:0] shade_out_q;

	function automatic logic [COORD_W-1:0] project(
		input logic [MAG_W-1:0] q,
		input logic neg,
		input logic zero,
		input logic [CFG_W-1:0] size
	);
		logic [SUM_W-1:0] qe;
		logic [SUM_W-1:0] sum;
		qe = zero ? '0 : SUM_W'(q);
		if (neg) begin
			qe = -qe;
		end
		sum = qe + SUM_W'(size[CFG_W-1:1]);
		return sum[COORD_W-1:0];
	endfunction

	spe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign idx_ext = IDX_CMP_W'(star_index);
	assign idx_ok = idx_ext < IDX_CMP_W'(STAR_SLOTS);
	assign accept = item_valid && !item_stall;

	always_comb begin
		if (new_depth == '0) begin
			depth_clamped = DEPTH_W'(1);
		end else if (DCMP_W'(new_depth) > DCMP_W'(DEPTH_MAX)) begin
			depth_clamped = DEPTH_W'(DEPTH_MAX);
		end else begin
			depth_clamped = new_depth;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			addr_q <= idx_ext[ADDR_W-1:0];
			nx_q <= new_x;
			ny_q <= new_y;
			nd_q <= depth_clamped;
		end
	end

	spe_ram #(
		.WIDTH (STAR_W),
		.DEPTH (STAR_SLOTS)
	) u_star_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	assign rd_x = rd_data[STAR_W-1 -: COORD_IN_W];
	assign rd_y = rd_data[DEPTH_W +: COORD_IN_W];
	assign rd_d = rd_data[DEPTH_W-1:0];

	always_comb begin
		if (op_q == OP_LOAD || rd_d <= cfg.fly_speed) begin
			ram_wdata = {nx_q, ny_q, nd_q};
		end else begin
			ram_wdata = {rd_x, rd_y, DEPTH_W'(rd_d - cfg.fly_speed)};
		end
	end

	assign abs_x = rd_x[COORD_IN_W-1] ? COORD_IN_W'(~rd_x + 1'b1) : rd_x;
	assign abs_y = rd_y[COORD_IN_W-1] ? COORD_IN_W'(~rd_y + 1'b1) : rd_y;
	assign dividend[0] = MAG_W'(abs_x) << PROJECTION_SHIFT;
	assign dividend[1] = MAG_W'(abs_y) << PROJECTION_SHIFT;

	spe_div #(
		.MAG_W (MAG_W),
		.DIV_W (DEPTH_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (rd_d),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		for (int j = 0; j < SHADE_STEPS; j++) begin
			shade_hit[j] = (SHC_W'(rd_d) << SHADE_SH) >= SHC_W'((j + 1) * DEPTH_MAX);
		end
		if (DCMP_W'(rd_d) < DCMP_W'(DOT_NEAR)) begin
			dot_d = DOT_W'(2);
		end else if (DCMP_W'(rd_d) < DCMP_W'(DOT_MID)) begin
			dot_d = DOT_W'(1);
		end else begin
			dot_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			negx_q <= rd_x[COORD_IN_W-1];
			negy_q <= rd_y[COORD_IN_W-1];
			dz_q <= rd_d == '0;
			dot_q <= dot_d;
			shade_q <= SHADE_W'(SHADE_TOP) - SHADE_W'($countones(shade_hit));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		item_stall = 1'b1;
		ram_we = 1'b0;
		div_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid && idx_ok) begin
					case (op)
						OP_LOAD: state_d = ST_WRITE;
						OP_ADVANCE, OP_DRAW: state_d = ST_READ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				state_d = (op_q == OP_DRAW) ? ST_SETUP : ST_WRITE;
			end
			ST_WRITE: begin
				ram_we = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SETUP: begin
				div_start = 1'b1;
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				load_out = !out_full_q || !result_stall;
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (load_out) begin
			out_full_q <= 1'b1;
		end else if (!result_stall) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sx_q <= project(quotient[0], negx_q, dz_q, cfg.screen_width);
			sy_q <= project(quotient[1], negy_q, dz_q, cfg.screen_height);
			dot_out_q <= dot_q;
			shade_out_q <= shade_q;
		end
	end

	assign result_valid = out_full_q;
	assign screen_x = sx_q;
	assign screen_y = sy_q;
	assign dot_size = dot_out_q;
	assign shade = shade_out_q;

endmodule

// File: rtl/spe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/spe_regs.sv
// APB-style configuration registers of the starfield projection engine.
module spe_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spe_pkg::PADDR_W-1:0]  paddr,
	input  logic [spe_pkg::PDATA_W-1:0]  pwdata,
	output logic [spe_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output spe_pkg::cfg_t                cfg
);

	import spe_pkg::*;

	cfg_t cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width <= SCREEN_WIDTH_RST;
			cfg_q.screen_height <= SCREEN_HEIGHT_RST;
			cfg_q.fly_speed <= FLY_SPEED_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[CFG_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[CFG_W-1:0];
				REG_FLY_SPEED: cfg_q.fly_speed <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCREEN_WIDTH: prdata = PDATA_W'(cfg_q.screen_width);
			REG_SCREEN_HEIGHT: prdata = PDATA_W'(cfg_q.screen_height);
			REG_FLY_SPEED: prdata = PDATA_W'(cfg_q.fly_speed);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/spe_div.sv
// Two-lane bit-serial restoring divider sharing one divisor and one step counter.
module spe_div #(
	parameter int MAG_W = 19,
	parameter int DIV_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0][MAG_W-1:0] dividend,
	input  logic [DIV_W-1:0]      divisor,
	output logic [1:0][MAG_W-1:0] quotient,
	output logic                  done
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] divisor_q;
	logic [1:0][DIV_W-1:0] rem_q;
	logic [1:0][MAG_W-1:0] dvd_q;
	logic [1:0][DIV_W:0] trial;
	logic [1:0] qbit;
	logic [1:0][DIV_W-1:0] rem_d;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = {rem_q[l], dvd_q[l][MAG_W-1]};
			qbit[l] = trial[l] >= {1'b0, divisor_q};
			rem_d[l] = qbit[l] ? DIV_W'(trial[l] - {1'b0, divisor_q})
				: trial[l][DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= '0;
				dvd_q[l] <= dividend[l];
			end
		end else if (busy_q) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= rem_d[l];
				dvd_q[l] <= {dvd_q[l][MAG_W-2:0], qbit[l]};
			end
		end
	end

	assign quotient = dvd_q;
	assign done = done_q;

endmodule

// File: verif/starfield_projection_engine_unit_tb.sv
// Testbench for the starfield projection engine: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module starfield_projection_engine_unit_tb;
	import spe_pkg::*;

	localparam int SLOTS = STAR_SLOTS_DEF;
	localparam int PROJ_SHIFT = PROJECTION_SHIFT_DEF;
	localparam int DEPTH_MAX = DEPTH_MAX_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 250;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [INDEX_W-1:0] idx;
		logic [COORD_IN_W-1:0] x;
		logic [COORD_IN_W-1:0] y;
		logic [DEPTH_W-1:0] d;
	} star_op_t;

	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [DOT_W-1:0] dot;
		logic [SHADE_W-1:0] shade;
	} proj_t;

	typedef struct packed {
		star_op_t beat;
		logic typed;
		proj_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [OP_W-1:0] op;
	logic [INDEX_W-1:0] star_index;
	logic signed [COORD_IN_W-1:0] new_x;
	logic signed [COORD_IN_W-1:0] new_y;
	logic [DEPTH_W-1:0] new_depth;
	logic result_valid;
	logic result_stall;
	logic signed [COORD_W-1:0] screen_x;
	logic signed [COORD_W-1:0] screen_y;
	logic [DOT_W-1:0] dot_size;
	logic [SHADE_W-1:0] shade;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	logic signed [COORD_IN_W-1:0] tbl_x [SLOTS];
	logic signed [COORD_IN_W-1:0] tbl_y [SLOTS];
	logic [DEPTH_W-1:0] tbl_depth [SLOTS];
	bit tbl_loaded [SLOTS];
	int loaded_list [$];
	logic [CFG_W-1:0] cfg_w;
	logic [CFG_W-1:0] cfg_h;
	logic [CFG_W-1:0] cfg_speed;

	proj_t expected_proj [$];
	dir_row_t directed_rows [$];
	int fault_count = 0;
	logic quiet;
	logic long_hold;
	int hold_serial;

	starfield_projection_engine_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.star_index(star_index),
		.new_x(new_x),
		.new_y(new_y),
		.new_depth(new_depth),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.screen_x(screen_x),
		.screen_y(screen_y),
		.dot_size(dot_size),
		.shade(shade),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	function automatic logic [COORD_W-1:0] perspective(input logic signed [COORD_IN_W-1:0] c,
			input logic [DEPTH_W-1:0] d, input logic [CFG_W-1:0] span);
		int mag;
		int quo;
		mag = (c < 0) ? -int'(c) : int'(c);
		quo = (d == '0) ? 0 : (mag << PROJ_SHIFT) / int'(d);
		if (c < 0) quo = -quo;
		return COORD_W'(quo + int'(span >> 1));
	endfunction

	task automatic store_star(input star_op_t it);
		logic [DEPTH_W-1:0] dep;
		dep = it.d;
		if (dep == '0) dep = DEPTH_W'(1);
		if (dep > DEPTH_W'(DEPTH_MAX)) dep = DEPTH_W'(DEPTH_MAX);
		tbl_x[it.idx] = it.x;
		tbl_y[it.idx] = it.y;
		tbl_depth[it.idx] = dep;
		if (!tbl_loaded[it.idx]) begin
			tbl_loaded[it.idx] = 1'b1;
			loaded_list.push_back(int'(it.idx));
		end
	endtask

	task automatic predict_star(input star_op_t it, output bit emits, output proj_t res);
		logic [DEPTH_W-1:0] dep;
		emits = 1'b0;
		res = '0;
		case (it.op)
			OP_LOAD: store_star(it);
			OP_ADVANCE: begin
				if (tbl_depth[it.idx] <= cfg_speed) store_star(it);
				else tbl_depth[it.idx] = tbl_depth[it.idx] - cfg_speed;
			end
			OP_DRAW: begin
				dep = tbl_depth[it.idx];
				emits = 1'b1;
				res.sx = perspective(tbl_x[it.idx], dep, cfg_w);
				res.sy = perspective(tbl_y[it.idx], dep, cfg_h);
				if (int'(dep) < DEPTH_MAX / 3) res.dot = DOT_W'(2);
				else if (int'(dep) < (2 * DEPTH_MAX) / 3) res.dot = DOT_W'(1);
				else res.dot = DOT_W'(0);
				res.shade = SHADE_W'(SHADE_TOP - (int'(dep) * SHADE_STEPS) / DEPTH_MAX);
			end
			default: ;
		endcase
	endtask

	task automatic send_beat(input star_op_t it, input logic typed, input proj_t typed_res);
		int gap;
		bit emits;
		proj_t res;
		gap = quiet ? 0 : int'($urandom_range(0, 4));
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= it.op;
		star_index <= it.idx;
		new_x <= it.x;
		new_y <= it.y;
		new_depth <= it.d;
		do @(posedge clk); while (item_stall);
		predict_star(it, emits, res);
		if (emits) expected_proj.push_back(typed ? typed_res : res);
	endtask

	task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wr ? PDATA_W'(value) : '0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata !== PDATA_W'(value)) begin
			if (fault_count < REPORT_MAX)
				$display("register %0d readback: expected %0d got %0d", idx, value, prdata);
			fault_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		apb_xfer(1'b1, idx, value);
		case (idx)
			REG_SCREEN_WIDTH: cfg_w = value;
			REG_SCREEN_HEIGHT: cfg_h = value;
			REG_FLY_SPEED: cfg_speed = value;
			default: ;
		endcase
		apb_xfer(1'b0, idx, value);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (expected_proj.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(input logic [OP_W-1:0] o, input int idx, input int x, input int y,
			input int d, input logic typed, input int ex, input int ey, input int edot,
			input int eshade);
		dir_row_t row;
		row.beat.op = o;
		row.beat.idx = INDEX_W'(idx);
		row.beat.x = COORD_IN_W'(x);
		row.beat.y = COORD_IN_W'(y);
		row.beat.d = DEPTH_W'(d);
		row.typed = typed;
		row.res.sx = COORD_W'(ex);
		row.res.sy = COORD_W'(ey);
		row.res.dot = DOT_W'(edot);
		row.res.shade = SHADE_W'(eshade);
		directed_rows.push_back(row);
	endtask

	initial begin : result_sink
		int rx_gap;
		proj_t want;
		rx_gap = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (expected_proj.size() == 0) begin
					if (fault_count < REPORT_MAX)
						$display("unexpected result x=%0d y=%0d dot=%0d shade=%0d",
							screen_x, screen_y, dot_size, shade);
					fault_count++;
				end else begin
					want = expected_proj.pop_front();
					if (screen_x !== want.sx || screen_y !== want.sy ||
							dot_size !== want.dot || shade !== want.shade) begin
						if (fault_count < REPORT_MAX) begin
							$display("result mismatch: expected x=%0d y=%0d dot=%0d shade=%0d",
								$signed(want.sx), $signed(want.sy), want.dot, want.shade);
							$display("                 got      x=%0d y=%0d dot=%0d shade=%0d",
								screen_x, screen_y, dot_size, shade);
						end
						fault_count++;
					end
				end
				rx_gap = quiet ? 0 : int'($urandom_range(0, 4));
			end
			if (rx_gap > 0) begin
				rx_gap--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= long_hold;
			end
		end
	end

	initial begin : hold_burst
		int hold_seen;
		hold_seen = 0;
		long_hold <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_serial != hold_seen) begin
				hold_seen = hold_serial;
				long_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold <= 1'b0;
			end
		end
	end

	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		star_op_t it;
		int count;
		int sel;
		int hot;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [CFG_W-1:0] spd;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		op <= OP_LOAD;
		star_index <= '0;
		new_x <= '0;
		new_y <= '0;
		new_depth <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		quiet <= 1'b0;
		hold_serial <= 0;
		for (int i = 0; i < SLOTS; i++) tbl_loaded[i] = 1'b0;
		cfg_w = SCREEN_WIDTH_RST;
		cfg_h = SCREEN_HEIGHT_RST;
		cfg_speed = FLY_SPEED_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_xfer(1'b0, REG_SCREEN_WIDTH, SCREEN_WIDTH_RST);
		apb_xfer(1'b0, REG_SCREEN_HEIGHT, SCREEN_HEIGHT_RST);
		apb_xfer(1'b0, REG_FLY_SPEED, FLY_SPEED_RST);

		add_row(OP_LOAD, 0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 0, 0, 0, 0, 1'b1, 160, 100, 2, 16);
		add_row(OP_LOAD, 1, 1023, -1024, 1024, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 1, 0, 0, 0, 1'b1, 415, -156, 0, 0);
		add_row(OP_LOAD, 2, -1024, 1023, 1, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 2, 0, 0, 0, 1'b1, -261984, 261988, 2, 16);
		add_row(OP_LOAD, 3, -1, 1, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 3, 0, 0, 0, 1'b1, -96, 356, 2, 16);
		add_row(OP_LOAD, 4, 5, -7, 2047, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 4, 0, 0, 0, 1'b1, 161, 99, 0, 0);
		add_row(OP_LOAD, 5, 300, -200, 340, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 5, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_LOAD, 6, -300, 200, 341, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 6, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_LOAD, 7, 17, 1000, 681, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 7, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_LOAD, 8, -999, -5, 682, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 8, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_ADVANCE, 5, 1, 1, 9, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 5, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_LOAD, 9, 10, 10, 4, 1'b0, 0, 0, 0, 0);
		add_row(OP_ADVANCE, 9, -50, 60, 500, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 9, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_UNUSED, 9, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		add_row(OP_DRAW, 9, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].res);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin w = 11'd1024; h = 11'd1024; spd = 11'd0; end
				1: begin w = 11'd1; h = 11'd1; spd = 11'd1024; end
				2: begin w = 11'd1; h = 11'd1024; spd = 11'd1; end
				3: begin
					w = CFG_W'($urandom_range(1, 1024));
					h = CFG_W'($urandom_range(1, 1024));
					spd = CFG_W'($urandom_range(1, 16));
				end
				default: begin
					w = CFG_W'($urandom_range(1, 1024));
					h = CFG_W'($urandom_range(1, 1024));
					spd = CFG_W'($urandom_range(0, 1024));
				end
			endcase
			program_reg(REG_SCREEN_WIDTH, w);
			program_reg(REG_SCREEN_HEIGHT, h);
			program_reg(REG_FLY_SPEED, spd);
			hold_serial <= hold_serial + 1;
			count = 0;
			while (count < PHASE_ITEMS) begin
				sel = int'($urandom_range(0, 99));
				hot = (loaded_list.size() < 8) ? loaded_list.size() : 8;
				if (loaded_list.size() == 0 || sel < 25) begin
					it.op = OP_LOAD;
					it.idx = ($urandom_range(0, 1) == 0) ? INDEX_W'($urandom_range(0, 15))
						: INDEX_W'($urandom_range(0, SLOTS - 1));
				end else if (sel < 95) begin
					it.op = (sel < 55) ? OP_ADVANCE : OP_DRAW;
					if ($urandom_range(0, 1) == 0)
						it.idx = INDEX_W'(loaded_list[$urandom_range(0, hot - 1)]);
					else
						it.idx = INDEX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
				end else begin
					it.op = OP_UNUSED;
					it.idx = INDEX_W'($urandom);
				end
				it.x = COORD_IN_W'($urandom);
				it.y = COORD_IN_W'($urandom);
				it.d = ($urandom_range(0, 9) == 0) ? DEPTH_W'($urandom)
					: DEPTH_W'($urandom_range(1, DEPTH_MAX));
				quiet <= ((count / 40) % 5) == 4;
				send_beat(it, 1'b0, '0);
				if (it.op != OP_UNUSED) count++;
			end
			quiet <= 1'b0;
			settle();
		end

		if (expected_proj.size() != 0) begin
			$display("%0d expected results never arrived", expected_proj.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
